@@ src/lfd_pkg.sv @@
// Shared types for the length-prefixed frame deframer.
package lfd_pkg;

   // One result transaction as it travels from the parser to the output stage.
   typedef struct packed {
      logic [7:0] payload_byte;
      logic [7:0] frame_operation;
      logic       end_of_frame;
      logic       empty_frame;
   } lfd_item_type;

   // Queue occupancy flags seen by the parser and the output stage.
   typedef struct packed {
      logic not_empty;
      logic full;
   } lfd_qstat_type;

endpackage

@@ src/lfd_parser.sv @@
// Front end: header parsing, length counting and result classification.
module lfd_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_rx_byte,
   input  logic                 csr_wr_en,
   input  logic [7:0]           csr_wr_data,
   input  lfd_pkg::lfd_qstat_type qstat,
   output logic                 push,
   output lfd_pkg::lfd_item_type  push_item
);
   import lfd_pkg::*;

   localparam logic [1:0] PH_HEAD = 2'd0;
   localparam logic [1:0] PH_LEN  = 2'd1;
   localparam logic [1:0] PH_EXT  = 2'd2;
   localparam logic [1:0] PH_DATA = 2'd3;

   localparam logic [6:0] LEN_DIRECT_MAX = 7'd125;
   localparam logic [6:0] LEN_EXT16      = 7'd126;
   localparam logic [3:0] EXT16_BYTES    = 4'd2;
   localparam logic [3:0] EXT64_BYTES    = 4'd8;

   logic [1:0]  phase_ff,  phase_in;
   logic [3:0]  ext_ff,    ext_in;
   logic [63:0] rem_ff,    rem_in;
   logic [7:0]  held_ff,   held_in;
   logic [7:0]  mask_ff;

   logic        accept;
   logic [6:0]  len_code;
   logic [63:0] rem_shift;
   logic [3:0]  ext_dec;
   logic        data_last;
   logic        res_valid;
   logic        res_empty;

   assign req_stall = qstat.full;
   assign accept    = req_valid && !qstat.full;
   assign len_code  = req_rx_byte[6:0];
   assign rem_shift = {rem_ff[55:0], req_rx_byte};
   assign ext_dec   = ext_ff - 4'd1;
   assign data_last = (rem_ff <= 64'd1);

   always_comb begin
      phase_in  = phase_ff;
      ext_in    = ext_ff;
      rem_in    = rem_ff;
      held_in   = held_ff;
      res_valid = 1'b0;
      res_empty = 1'b0;
      unique case (phase_ff)
         PH_LEN: begin
            if (len_code == 7'd0) begin
               // zero length: emit the empty-frame marker
               phase_in  = PH_HEAD;
               rem_in    = 64'd0;
               res_valid = 1'b1;
               res_empty = 1'b1;
            end else if (len_code <= LEN_DIRECT_MAX) begin
               rem_in   = {57'd0, len_code};
               phase_in = PH_DATA;
            end else begin
               ext_in   = (len_code == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
               rem_in   = 64'd0;
               phase_in = PH_EXT;
            end
         end
         PH_EXT: begin
            rem_in = rem_shift;
            ext_in = ext_dec;
            if (ext_dec == 4'd0) begin
               if (rem_shift == 64'd0) begin
                  phase_in  = PH_HEAD;
                  res_valid = 1'b1;
                  res_empty = 1'b1;
               end else begin
                  phase_in = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            rem_in    = data_last ? 64'd0 : rem_ff - 64'd1;
            res_valid = 1'b1;
            if (data_last) begin
               phase_in = PH_HEAD;
            end
         end
         default: begin
            held_in  = req_rx_byte & mask_ff;
            ext_in   = 4'd0;
            rem_in   = 64'd0;
            phase_in = PH_LEN;
         end
      endcase
   end

   assign push                      = accept && res_valid;
   assign push_item.payload_byte    = res_empty ? 8'd0 : req_rx_byte;
   assign push_item.frame_operation = held_ff;
   assign push_item.end_of_frame    = res_empty || data_last;
   assign push_item.empty_frame     = res_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEAD;
         ext_ff   <= 4'd0;
         rem_ff   <= 64'd0;
         held_ff  <= 8'd0;
         mask_ff  <= 8'hFF;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            ext_ff   <= ext_in;
            rem_ff   <= rem_in;
            held_ff  <= held_in;
         end
         if (csr_wr_en) begin
            mask_ff <= csr_wr_data;
         end
      end
   end

endmodule

@@ src/lfd_queue.sv @@
// Small result queue that decouples the parser from the output stage.
module lfd_queue #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  lfd_pkg::lfd_item_type push_item,
   input  logic                  pop,
   output lfd_pkg::lfd_item_type head_item,
   output lfd_pkg::lfd_qstat_type qstat
);
   import lfd_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   lfd_item_type  mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff,  count_in;

   assign head_item       = mem_ff[rd_ptr_ff];
   assign qstat.not_empty = (count_ff != '0);
   assign qstat.full      = (count_ff == FULL_CNT);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ src/lfd_emitter.sv @@
// Back end: output register that drains the queue onto the result channel.
module lfd_emitter (
   input  logic                   clock,
   input  logic                   reset,
   input  lfd_pkg::lfd_item_type  head_item,
   input  lfd_pkg::lfd_qstat_type qstat,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_payload_byte,
   output logic [7:0]             rsp_frame_operation,
   output logic                   rsp_end_of_frame,
   output logic                   rsp_empty_frame
);
   import lfd_pkg::*;

   logic         valid_ff;
   lfd_item_type item_ff;

   // load whenever the queue holds a result and the register is empty or its transaction leaves this cycle
   assign pop = qstat.not_empty && (!valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (pop) begin
         item_ff <= head_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_payload_byte    = item_ff.payload_byte;
   assign rsp_frame_operation = item_ff.frame_operation;
   assign rsp_end_of_frame    = item_ff.end_of_frame;
   assign rsp_empty_frame     = item_ff.empty_frame;

endmodule

@@ src/length_prefixed_frame_deframer.sv @@
// Top level of the length-prefixed frame deframer.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_rx_byte
//   rsp      out        rsp_valid / rsp_stall  payload, operation, end, empty flags
//   csr      in         csr_wr_en              csr_wr_data (operation mask)
//
// One byte is accepted per cycle while the result queue has room; a payload byte
// or empty-frame marker is written into the queue at the edge that accepts its
// byte and then moves into the output register that drives rsp_valid. The parser's
// length counter is 64 bits wide. Reset is synchronous and returns the parser to
// expecting a first header byte, empties the queue and sets the mask to all ones.
// A stalled rsp side fills the queue; req_stall rises only when it is full.
module length_prefixed_frame_deframer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_payload_byte,
   output logic [7:0] rsp_frame_operation,
   output logic       rsp_end_of_frame,
   output logic       rsp_empty_frame,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);
   import lfd_pkg::*;

   lfd_qstat_type qstat;
   lfd_item_type  push_item;
   lfd_item_type  head_item;
   logic          push;
   logic          pop;

   // Parse headers and classify each byte; push a transaction for every result.
   lfd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .qstat       (qstat),
      .push        (push),
      .push_item   (push_item)
   );

   // Hold pending results so either side can stall on its own.
   lfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .qstat     (qstat)
   );

   // Advance queued results into the output register.
   lfd_emitter u_emitter (
      .clock               (clock),
      .reset               (reset),
      .head_item           (head_item),
      .qstat               (qstat),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_frame_operation (rsp_frame_operation),
      .rsp_end_of_frame    (rsp_end_of_frame),
      .rsp_empty_frame     (rsp_empty_frame)
   );

endmodule
